FILE: src/lsfe_pkg.sv
// lsfe_pkg: shared types, codes and constants for the lsb frame extractor
// used by lsfe_parser, lsfe_out_buf and lsb_stego_frame_extractor
`default_nettype none

package lsfe_pkg;

  localparam int HEADER_BITS_DEF = 32;
  localparam int WORD_BITS       = 32;
  localparam int BYTE_BITS       = 8;
  localparam int COUNT_BITS      = 6;

  localparam logic [2:0] KIND_CHECKSUM = 3'd0;
  localparam logic [2:0] KIND_NAME_LEN = 3'd1;
  localparam logic [2:0] KIND_DATA_LEN = 3'd2;
  localparam logic [2:0] KIND_NAME     = 3'd3;
  localparam logic [2:0] KIND_DATA     = 3'd4;

  typedef enum logic [2:0] {
    PH_CHECKSUM = 3'd0,
    PH_NAME_LEN = 3'd1,
    PH_DATA_LEN = 3'd2,
    PH_NAME     = 3'd3,
    PH_DATA     = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       start_req;
  } in_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [WORD_BITS-1:0] value;
    logic                 last;
  } out_t;

endpackage

`default_nettype wire

FILE: src/lsb_stego_frame_extractor.sv
// lsb_stego_frame_extractor: top level of the lsb frame extractor
// depends on lsfe_pkg, lsfe_parser and lsfe_out_buf
//
// usage
// - input channel (in_valid, in_stall, in_data): one pixel per transaction;
//   bit 0 of pixel is shifted in msb first, start_req restarts the parse
//   with this pixel as the first bit of a new frame
// - result channel (out_valid, out_stall, out_data): checksum, name length
//   and data length headers, then name and data bytes, tagged by kind;
//   last marks the final result of the frame
// - throughput: one pixel per cycle while in_stall is low, set by the single parser stage
// - each result is registered in the output buffer before it is presented
// - a receiver stall parks results in the output register and one skid
//   entry; in_stall rises only while the skid entry is occupied
// - reset clears the parse state to the checksum phase and empties the
//   output buffer; after the frame ends pixels are dropped until start_req
`default_nettype none

module lsb_stego_frame_extractor #(
  parameter int HEADER_BITS = lsfe_pkg::HEADER_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire lsfe_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output lsfe_pkg::out_t       out_data
);
  import lsfe_pkg::*;

  logic accept;
  logic push;
  out_t push_item;
  logic full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  lsfe_parser #(
    .HEADER_BITS(HEADER_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_data),
    .push      (push),
    .push_item (push_item)
  );

  lsfe_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: src/lsfe_parser.sv
// lsfe_parser: shifts in pixel lsbs and tracks header and body phases
// depends on lsfe_pkg; emits at most one result per accepted pixel
`default_nettype none

module lsfe_parser #(
  parameter int HEADER_BITS = lsfe_pkg::HEADER_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire lsfe_pkg::in_t  in_item,
  output logic              push,
  output lsfe_pkg::out_t    push_item
);
  import lsfe_pkg::*;

  // header width limited to 8..32 bits
  localparam int HDR_BITS = (HEADER_BITS > WORD_BITS) ? WORD_BITS :
                            ((HEADER_BITS < BYTE_BITS) ? BYTE_BITS : HEADER_BITS);

  localparam logic [WORD_BITS-1:0] HDR_MASK =
    WORD_BITS'((64'd1 << HDR_BITS) - 64'd1);
  localparam logic [WORD_BITS-1:0] BYTE_MASK =
    WORD_BITS'((64'd1 << BYTE_BITS) - 64'd1);
  localparam logic [COUNT_BITS-1:0] HDR_NEED  = COUNT_BITS'(HDR_BITS);
  localparam logic [COUNT_BITS-1:0] BYTE_NEED = COUNT_BITS'(BYTE_BITS);

  phase_t                phase_r, phase_nxt, eff_phase;
  logic [WORD_BITS-1:0]  shift_r, shift_nxt, eff_shift;
  logic [COUNT_BITS-1:0] count_r, count_nxt, eff_count;
  logic [WORD_BITS-1:0]  name_len_r, name_len_nxt, eff_name_len;
  logic [WORD_BITS-1:0]  data_len_r, data_len_nxt, eff_data_len;
  logic [WORD_BITS-1:0]  bytes_r, bytes_nxt, eff_bytes;

  logic                  is_hdr;
  logic [COUNT_BITS-1:0] need;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [WORD_BITS-1:0]  bytes_inc;
  logic [WORD_BITS-1:0]  shifted;

  always_comb begin
    if (in_item.start_req) begin
      eff_phase    = PH_CHECKSUM;
      eff_shift    = '0;
      eff_count    = '0;
      eff_name_len = '0;
      eff_data_len = '0;
      eff_bytes    = '0;
    end else begin
      eff_phase    = phase_r;
      eff_shift    = shift_r;
      eff_count    = count_r;
      eff_name_len = name_len_r;
      eff_data_len = data_len_r;
      eff_bytes    = bytes_r;
    end
    is_hdr    = (eff_phase == PH_CHECKSUM) || (eff_phase == PH_NAME_LEN) ||
                (eff_phase == PH_DATA_LEN);
    need      = is_hdr ? HDR_NEED : BYTE_NEED;
    shifted   = {eff_shift[WORD_BITS-2:0], in_item.pixel[0]} &
                (is_hdr ? HDR_MASK : BYTE_MASK);
    cnt_inc   = eff_count + COUNT_BITS'(1);
    bytes_inc = eff_bytes + WORD_BITS'(1);
  end

  always_comb begin
    phase_nxt    = phase_r;
    shift_nxt    = shift_r;
    count_nxt    = count_r;
    name_len_nxt = name_len_r;
    data_len_nxt = data_len_r;
    bytes_nxt    = bytes_r;
    push         = 1'b0;
    push_item    = '0;
    if (accept) begin
      phase_nxt    = eff_phase;
      shift_nxt    = eff_shift;
      count_nxt    = eff_count;
      name_len_nxt = eff_name_len;
      data_len_nxt = eff_data_len;
      bytes_nxt    = eff_bytes;
      if (is_hdr || (eff_phase == PH_NAME) || (eff_phase == PH_DATA)) begin
        shift_nxt = shifted;
        count_nxt = cnt_inc;
        if (cnt_inc >= need) begin
          shift_nxt       = '0;
          count_nxt       = '0;
          push            = 1'b1;
          push_item.value = shifted;
          case (eff_phase)
            PH_CHECKSUM: begin
              phase_nxt      = PH_NAME_LEN;
              push_item.kind = KIND_CHECKSUM;
            end
            PH_NAME_LEN: begin
              name_len_nxt   = shifted;
              phase_nxt      = PH_DATA_LEN;
              push_item.kind = KIND_NAME_LEN;
            end
            PH_DATA_LEN: begin
              data_len_nxt   = shifted;
              bytes_nxt      = '0;
              push_item.kind = KIND_DATA_LEN;
              if (eff_name_len != '0) begin
                phase_nxt = PH_NAME;
              end else if (shifted != '0) begin
                phase_nxt = PH_DATA;
              end else begin
                phase_nxt      = PH_DONE;
                push_item.last = 1'b1;
              end
            end
            PH_NAME: begin
              push_item.kind = KIND_NAME;
              bytes_nxt      = bytes_inc;
              if (bytes_inc >= eff_name_len) begin
                bytes_nxt = '0;
                if (eff_data_len != '0) begin
                  phase_nxt = PH_DATA;
                end else begin
                  phase_nxt      = PH_DONE;
                  push_item.last = 1'b1;
                end
              end
            end
            default: begin
              push_item.kind = KIND_DATA;
              bytes_nxt      = bytes_inc;
              if (bytes_inc >= eff_data_len) begin
                bytes_nxt      = '0;
                phase_nxt      = PH_DONE;
                push_item.last = 1'b1;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CHECKSUM;
      shift_r    <= '0;
      count_r    <= '0;
      name_len_r <= '0;
      data_len_r <= '0;
      bytes_r    <= '0;
    end else begin
      phase_r    <= phase_nxt;
      shift_r    <= shift_nxt;
      count_r    <= count_nxt;
      name_len_r <= name_len_nxt;
      data_len_r <= data_len_nxt;
      bytes_r    <= bytes_nxt;
    end
  end

  a_count_below_header: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < HDR_NEED)
    else $error("bit count reached header width");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_item.last |=> phase_r == PH_DONE)
    else $error("last result did not end the frame");

  a_done_clears_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |-> bytes_r == '0 && count_r == '0)
    else $error("done phase holds stale counters");

endmodule

`default_nettype wire

FILE: src/lsfe_out_buf.sv
// lsfe_out_buf: output register with one skid entry for the result channel
// depends on lsfe_pkg for the result struct
`default_nettype none

module lsfe_out_buf (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire lsfe_pkg::out_t  push_item,
  output logic                 full,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output lsfe_pkg::out_t       out_data
);
  import lsfe_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  out_t main_r, main_nxt;
  out_t skid_r, skid_nxt;
  logic pop;

  assign pop       = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = main_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        main_nxt      = push_item;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_item;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output entry");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled result dropped");

  a_skid_drains_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && pop |=> main_r == $past(skid_r))
    else $error("skid entry not moved to output");

endmodule

`default_nettype wire

FILE: tb/tb_lsb_stego_frame_extractor.sv
// tb_lsb_stego_frame_extractor: self-checking testbench for the lsb frame extractor
// streams hidden frames through random valid/stall gaps and checks every result
// against an in-bench predictor; depends on lsfe_pkg and lsb_stego_frame_extractor
`default_nettype none

module tb_lsb_stego_frame_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  import lsfe_pkg::*;

  localparam int HEADER_BITS = HEADER_BITS_DEF;
  localparam int HDR = (HEADER_BITS > 32) ? 32 : ((HEADER_BITS < 8) ? 8 : HEADER_BITS);

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  lsb_stego_frame_extractor #(.HEADER_BITS(HEADER_BITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  in_t  pixel_q[$];
  out_t recovered_q[$];
  int   pixels_queued = 0;
  int   errors = 0;

  // parse state of the predictor
  phase_t      ph_q = PH_CHECKSUM;
  logic [31:0] shift_q = '0;
  logic [5:0]  cnt_q = '0;
  logic [31:0] nlen_q = '0;
  logic [31:0] dlen_q = '0;
  logic [31:0] bytes_q = '0;

  task automatic clear_parse();
    ph_q = PH_CHECKSUM;
    shift_q = '0;
    cnt_q = '0;
    nlen_q = '0;
    dlen_q = '0;
    bytes_q = '0;
  endtask

  task automatic extract_pixel(input in_t px);
    int          need;
    logic [31:0] mask;
    logic [31:0] word;
    out_t        res;
    if (px.start_req) clear_parse();
    if (ph_q >= PH_DONE) return;
    need = (ph_q <= PH_DATA_LEN) ? HDR : BYTE_BITS;
    mask = (need >= 32) ? '1 : ((32'd1 << need) - 32'd1);
    shift_q = ((shift_q << 1) | 32'(px.pixel[0])) & mask;
    cnt_q = cnt_q + 6'd1;
    if (cnt_q < need) return;
    word = shift_q;
    shift_q = '0;
    cnt_q = '0;
    case (ph_q)
      PH_CHECKSUM: begin
        ph_q = PH_NAME_LEN;
        res.kind = KIND_CHECKSUM;
      end
      PH_NAME_LEN: begin
        nlen_q = word;
        ph_q = PH_DATA_LEN;
        res.kind = KIND_NAME_LEN;
      end
      PH_DATA_LEN: begin
        dlen_q = word;
        bytes_q = '0;
        if (nlen_q != 0) ph_q = PH_NAME;
        else if (dlen_q != 0) ph_q = PH_DATA;
        else ph_q = PH_DONE;
        res.kind = KIND_DATA_LEN;
      end
      PH_NAME: begin
        bytes_q = bytes_q + 32'd1;
        if (bytes_q >= nlen_q) begin
          bytes_q = '0;
          if (dlen_q != 0) ph_q = PH_DATA;
          else ph_q = PH_DONE;
        end
        res.kind = KIND_NAME;
      end
      default: begin
        bytes_q = bytes_q + 32'd1;
        if (bytes_q >= dlen_q) begin
          bytes_q = '0;
          ph_q = PH_DONE;
        end
        res.kind = KIND_DATA;
      end
    endcase
    res.value = word;
    res.last = (ph_q == PH_DONE);
    recovered_q.push_back(res);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (recovered_q.size() == 0) begin
      $error("unexpected result: kind %0d value %h last %0d", got.kind, got.value, got.last);
      errors++;
      return;
    end
    want = recovered_q.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, actual %0d", want.kind, got.kind);
      errors++;
    end
    if (got.value !== want.value) begin
      $error("value: expected %h, actual %h", want.value, got.value);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, actual %0d", want.last, got.last);
      errors++;
    end
  endtask

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // transaction acceptance, prediction and checking
  logic in_fired = 1'b0;

  always @(posedge clk) begin
    in_fired <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) extract_pixel(in_data);
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  // pixel driver
  int in_gap = 0;
  bit in_quiet = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pixel_q.size() != 0) begin
        in_data <= pixel_q.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 99) == 0) in_quiet = ~in_quiet;
        in_gap = pick_gap(in_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit out_quiet = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && ph_q == PH_NAME && nlen_q >= 10) begin
      // long hold-off while the sender keeps going, so the block backs up
      hold_done = 1'b1;
      hold_left = 150;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 99) == 0) out_quiet = ~out_quiet;
      stall_left = pick_gap(out_quiet);
    end
  end

  task automatic push_pixel(input logic b, input logic st);
    in_t it;
    it.pixel = {7'($urandom_range(0, 127)), b};
    it.start_req = st;
    pixel_q.push_back(it);
    pixels_queued++;
  endtask

  task automatic push_raw(input logic [7:0] px, input logic st);
    in_t it;
    it.pixel = px;
    it.start_req = st;
    pixel_q.push_back(it);
    pixels_queued++;
  endtask

  task automatic push_bits(input logic [31:0] w, input int n, input logic st);
    for (int i = n - 1; i >= 0; i--) push_pixel(w[i], st && (i == n - 1));
  endtask

  task automatic push_frame(input logic [31:0] chk, input logic [31:0] nlen,
                            input logic [31:0] dlen, input int nb, input int db,
                            input int tail);
    push_bits(chk, HDR, 1'b1);
    push_bits(nlen, HDR, 1'b0);
    push_bits(dlen, HDR, 1'b0);
    repeat (nb) push_bits($urandom, BYTE_BITS, 1'b0);
    repeat (db) push_bits($urandom, BYTE_BITS, 1'b0);
    repeat (tail) push_pixel(1'($urandom_range(0, 1)), 1'b0);
  endtask

  initial begin
    int r;
    int nl;
    int dl;
    int nb;
    int db;
    int n;

    // single pixels with extreme values and restarts
    push_raw(8'h00, 1'b1);
    push_raw(8'hFF, 1'b0);
    push_raw(8'hFE, 1'b0);
    push_raw(8'h01, 1'b1);
    push_raw(8'h80, 1'b0);
    push_raw(8'h7F, 1'b1);
    push_raw(8'hFF, 1'b1);
    push_raw(8'h00, 1'b0);

    // both lengths zero, then ignored pixels in the done phase
    push_frame(32'hFFFF_FFFF, 32'd0, 32'd0, 0, 0, 12);
    // long body for the receiver hold-off
    push_frame(32'h0000_0000, 32'd12, 32'd10, 12, 10, 4);
    // zero name length
    push_frame($urandom, 32'd0, 32'd2, 0, 2, 3);
    // zero data length
    push_frame($urandom, 32'd2, 32'd0, 2, 0, 5);
    push_frame(32'hA5A5_5A5A, 32'd1, 32'd1, 1, 1, 0);
    // restart in the middle of a name byte and of a header word
    push_frame($urandom, 32'd3, 32'd3, 1, 0, 3);
    push_bits($urandom, HDR, 1'b1);
    push_bits($urandom, 17, 1'b0);
    // maximum lengths, cut short
    push_frame($urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 0, 0);
    push_frame($urandom, 32'd0, 32'hFFFF_FFFF, 0, 2, 2);

    while (pixels_queued < 1100) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        nl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
        dl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
        push_frame($urandom, nl, dl, nl, dl, $urandom_range(0, 6));
      end else if (r == 7) begin
        nl = $urandom_range(1, 4);
        dl = $urandom_range(1, 4);
        nb = $urandom_range(0, nl);
        db = (nb == nl) ? $urandom_range(0, dl - 1) : 0;
        push_frame($urandom, nl, dl, nb, db, $urandom_range(0, 7));
      end else if (r == 8) begin
        n = $urandom_range(1, 12);
        repeat (n) push_pixel(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      end else begin
        push_frame($urandom, $urandom, $urandom, $urandom_range(0, 3), 0, 0);
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pixel_q.size() != 0 || in_valid) @(posedge clk);
    n = 0;
    while (recovered_q.size() != 0 && n < 2000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
    if (recovered_q.size() != 0) begin
      $error("%0d expected results never arrived", recovered_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
src/lsfe_pkg.sv
src/lsfe_parser.sv
src/lsfe_out_buf.sv
src/lsb_stego_frame_extractor.sv
tb/tb_lsb_stego_frame_extractor.sv
